@@ hdl/fwr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fwr_pkg;

    // Frame delimiters
    localparam logic [7:0] HEAD_BYTE = 8'h12;
    localparam logic [7:0] TAIL_BYTE = 8'h5B;

    // Field widths fixed by the result format
    localparam int OFFSET_W = 5;
    localparam int WORDS_W  = 4;
    // offset + 2 * index + 1 fits here
    localparam int ADDR_EXT_W = 6;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FIRST_OFFSET  = 2'd0,
        CFG_FIRST_WORDS   = 2'd1,
        CFG_SECOND_OFFSET = 2'd2,
        CFG_SECOND_WORDS  = 2'd3
    } t_cfg_index;

    // Group status codes
    typedef enum logic [2:0] {
        STAT_NORMAL    = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_LOST      = 3'd2,
        STAT_DROPPED   = 3'd3,
        STAT_IDLE      = 3'd4
    } t_status;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_SECOND = 2'd2
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_USE,
        S_JUDGE
    } t_state;

    // One result beat
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  word_index;
        logic [15:0] word_value;
        t_status     first_status;
        t_status     second_status;
        logic        last;
    } t_result;

    // Re-evaluate a group status; a dropped frame holds until a frame closes
    function automatic t_status judge(input t_status code, input logic zero,
                                      input logic seen);
        t_status res;
        res = code;
        if (code != STAT_DROPPED) begin
            if (zero) begin
                res = seen ? STAT_LOST : STAT_NOT_FOUND;
            end else begin
                res = STAT_NORMAL;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fwr_byte_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fwr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/fwr_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fwr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic [2:0]  first_status;
    logic [2:0]  second_status;
    logic        last;

    modport source (output valid, output kind, output word_index, output word_value,
                    output first_status, output second_status, output last,
                    input ready);
    modport sink   (input valid, input kind, input word_index, input word_value,
                    input first_status, input second_status, input last,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/fwr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/framed_word_receiver_with_status.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Framed word receiver. Bytes enter on i_rx one beat each; frames open with
// 0x12 and close with 0x5B. Every byte of a frame is written into a byte RAM.
// A byte that does not start a readout gives one status beat on o_res in the
// cycle after it is taken. A closing byte with words to report starts a readout:
// a scan pass reads every group byte to find whether each group is all
// zero, a judge state settles the statuses, then an emit pass reads the
// bytes again and sends one beat per word. The single RAM port and its
// registered read pace the readout. i_rx is held off during the readout.
// A stalled o_res holds its beat and stops i_rx and the readout until
// taken. Buffer bytes never written in the current frame read as zero
// through the fill count, so no clearing pass is needed. Reset clears the
// frame state and the configuration and sets both statuses to not
// evaluated. Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data.
module framed_word_receiver_with_status #(
    parameter int BUF_BYTES = 32,
    parameter int MAX_WORDS = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data,
    fwr_byte_if.sink        i_rx,
    fwr_res_if.source       o_res
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = $clog2(BUF_BYTES + 1);

    // Configuration
    logic [fwr_pkg::OFFSET_W-1:0] r_first_offset, r_second_offset;
    logic [fwr_pkg::WORDS_W-1:0]  r_first_words, r_second_words;

    // Frame and status state
    fwr_pkg::t_state  r_state, n_state;
    logic             r_in_frame, n_in_frame;
    logic [CW-1:0]    r_count, n_count;
    logic             r_first_zero, n_first_zero;
    logic             r_second_zero, n_second_zero;
    logic             r_first_seen, n_first_seen;
    logic             r_second_seen, n_second_seen;
    fwr_pkg::t_status r_first_code, n_first_code;
    fwr_pkg::t_status r_second_code, n_second_code;

    // Readout position
    logic                        r_emit, n_emit;
    logic                        r_grp, n_grp;
    logic [fwr_pkg::WORDS_W-1:0] r_idx, n_idx;
    logic                        r_lo, n_lo;
    logic [7:0]                  r_hi_byte, n_hi_byte;
    logic                        r_rd_ok;

    // Output register
    logic             r_ov, n_ov;
    fwr_pkg::t_result r_out, n_out;

    // RAM signals
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Decode helpers
    logic [fwr_pkg::WORDS_W-1:0]    n1, n2, cur_n;
    logic [fwr_pkg::OFFSET_W-1:0]   cur_off;
    logic [fwr_pkg::ADDR_EXT_W-1:0] rd_addr_ext;
    logic                           rd_ok;
    logic [7:0]                     rd_byte;
    logic                           word_done, pos_end;
    logic                           out_free, rx_accept;
    logic                           is_head, store, stray, close, ovf, empty_grp;
    logic                           start_grp;
    fwr_pkg::t_status               f_code_in, s_code_in;
    logic                           f_zero_in, s_zero_in;

    // Clamp word counts
    assign n1 = (int'(r_first_words) > MAX_WORDS)
                ? fwr_pkg::WORDS_W'(MAX_WORDS) : r_first_words;
    assign n2 = (int'(r_second_words) > MAX_WORDS)
                ? fwr_pkg::WORDS_W'(MAX_WORDS) : r_second_words;

    // Current read address and its fill-count check
    assign cur_off     = r_grp ? r_second_offset : r_first_offset;
    assign cur_n       = r_grp ? n2 : n1;
    assign rd_addr_ext = {1'b0, cur_off} + {1'b0, r_idx, 1'b0}
                         + fwr_pkg::ADDR_EXT_W'(r_lo);
    assign rd_ok       = int'(rd_addr_ext) < int'(r_count);
    assign ram_re      = (r_state == fwr_pkg::S_READ);
    assign ram_raddr   = rd_ok ? AW'(rd_addr_ext) : '0;
    assign rd_byte     = r_rd_ok ? ram_rdata : 8'h00;

    assign word_done = (r_idx + 4'd1) == cur_n;
    assign pos_end   = r_lo && word_done && (r_grp || (n2 == '0));
    assign start_grp = (n1 == '0);

    // Handshake
    assign out_free    = !r_ov || o_res.ready;
    assign i_rx.ready  = (r_state == fwr_pkg::S_IDLE) && out_free;
    assign rx_accept   = i_rx.valid && i_rx.ready;

    // Classify the incoming byte
    assign is_head   = (i_rx.rx_byte == fwr_pkg::HEAD_BYTE);
    assign store     = is_head || r_in_frame;
    assign stray     = !store;
    assign close     = r_in_frame && !is_head && (i_rx.rx_byte == fwr_pkg::TAIL_BYTE);
    assign ovf       = store && !close && ((int'(r_count) + 1) == BUF_BYTES);
    assign empty_grp = (n1 == '0) && (n2 == '0);

    // Status inputs for a byte taken in idle
    always_comb begin
        if (close) begin
            f_code_in = fwr_pkg::STAT_NORMAL;
            s_code_in = fwr_pkg::STAT_NORMAL;
            f_zero_in = 1'b1;
            s_zero_in = 1'b1;
        end else begin
            f_code_in = (stray || ovf) ? fwr_pkg::STAT_DROPPED : r_first_code;
            s_code_in = (stray || ovf) ? fwr_pkg::STAT_DROPPED : r_second_code;
            f_zero_in = r_first_zero;
            s_zero_in = r_second_zero;
        end
    end

    assign ram_we = rx_accept && store;

    fwr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx.rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fwr_pkg::S_IDLE: begin
                if (rx_accept && close && !empty_grp) begin
                    n_state = fwr_pkg::S_READ;
                end
            end
            fwr_pkg::S_READ: begin
                n_state = fwr_pkg::S_USE;
            end
            fwr_pkg::S_USE: begin
                if (!r_emit) begin
                    n_state = pos_end ? fwr_pkg::S_JUDGE : fwr_pkg::S_READ;
                end else if (!r_lo) begin
                    n_state = fwr_pkg::S_READ;
                end else if (out_free) begin
                    n_state = pos_end ? fwr_pkg::S_IDLE : fwr_pkg::S_READ;
                end
            end
            fwr_pkg::S_JUDGE: begin
                n_state = fwr_pkg::S_READ;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_in_frame    = r_in_frame;
        n_count       = r_count;
        n_first_zero  = r_first_zero;
        n_second_zero = r_second_zero;
        n_first_seen  = r_first_seen;
        n_second_seen = r_second_seen;
        n_first_code  = r_first_code;
        n_second_code = r_second_code;
        n_emit        = r_emit;
        n_grp         = r_grp;
        n_idx         = r_idx;
        n_lo          = r_lo;
        n_hi_byte     = r_hi_byte;
        n_ov          = r_ov && !o_res.ready;
        n_out         = r_out;

        unique case (r_state)
            fwr_pkg::S_IDLE: begin
                if (rx_accept) begin
                    if (store) begin
                        n_count    = r_count + CW'(1);
                        n_in_frame = 1'b1;
                    end
                    if (close && !empty_grp) begin
                        // start the scan pass with the frame length frozen
                        n_in_frame    = 1'b0;
                        n_first_zero  = 1'b1;
                        n_second_zero = 1'b1;
                        n_emit        = 1'b0;
                        n_grp         = start_grp;
                        n_idx         = '0;
                        n_lo          = 1'b0;
                    end else begin
                        if (close || ovf) begin
                            n_count    = '0;
                            n_in_frame = 1'b0;
                        end
                        n_first_zero  = f_zero_in;
                        n_second_zero = s_zero_in;
                        n_first_code  = fwr_pkg::judge(f_code_in, f_zero_in, r_first_seen);
                        n_second_code = fwr_pkg::judge(s_code_in, s_zero_in, r_second_seen);
                        n_first_seen  = r_first_seen ||
                                        (f_code_in != fwr_pkg::STAT_DROPPED && !f_zero_in);
                        n_second_seen = r_second_seen ||
                                        (s_code_in != fwr_pkg::STAT_DROPPED && !s_zero_in);
                        n_ov                  = 1'b1;
                        n_out.kind            = fwr_pkg::KIND_STATUS;
                        n_out.word_index      = '0;
                        n_out.word_value      = '0;
                        n_out.first_status    = n_first_code;
                        n_out.second_status   = n_second_code;
                        n_out.last            = 1'b1;
                    end
                end
            end
            fwr_pkg::S_READ: begin
            end
            fwr_pkg::S_USE: begin
                if (!r_emit) begin
                    // scan: drop the zero flag of the group on any nonzero byte
                    if (rd_byte != 8'h00) begin
                        if (r_grp) begin
                            n_second_zero = 1'b0;
                        end else begin
                            n_first_zero = 1'b0;
                        end
                    end
                end else if (!r_lo) begin
                    n_hi_byte = rd_byte;
                end else if (out_free) begin
                    n_ov                = 1'b1;
                    n_out.kind          = r_grp ? fwr_pkg::KIND_SECOND : fwr_pkg::KIND_FIRST;
                    n_out.word_index    = r_idx;
                    n_out.word_value    = {r_hi_byte, rd_byte};
                    n_out.first_status  = r_first_code;
                    n_out.second_status = r_second_code;
                    n_out.last          = pos_end;
                    if (pos_end) begin
                        n_count = '0;
                    end
                end

                // advance the read position unless the beat is held or the pass is at its end
                if (!(r_emit && r_lo && !out_free) && !pos_end) begin
                    if (!r_lo) begin
                        n_lo = 1'b1;
                    end else if (!word_done) begin
                        n_idx = r_idx + 4'd1;
                        n_lo  = 1'b0;
                    end else begin
                        n_grp = 1'b1;
                        n_idx = '0;
                        n_lo  = 1'b0;
                    end
                end
            end
            fwr_pkg::S_JUDGE: begin
                // a closed frame clears any drop, then each group is judged
                n_first_code  = fwr_pkg::judge(fwr_pkg::STAT_NORMAL, r_first_zero,
                                               r_first_seen);
                n_second_code = fwr_pkg::judge(fwr_pkg::STAT_NORMAL, r_second_zero,
                                               r_second_seen);
                n_first_seen  = r_first_seen || !r_first_zero;
                n_second_seen = r_second_seen || !r_second_zero;
                n_emit        = 1'b1;
                n_grp         = start_grp;
                n_idx         = '0;
                n_lo          = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_offset  <= '0;
            r_first_words   <= '0;
            r_second_offset <= '0;
            r_second_words  <= '0;
        end else if (i_cfg_we) begin
            unique case (fwr_pkg::t_cfg_index'(i_cfg_index))
                fwr_pkg::CFG_FIRST_OFFSET:  r_first_offset  <= i_cfg_data;
                fwr_pkg::CFG_FIRST_WORDS:   r_first_words   <= i_cfg_data[3:0];
                fwr_pkg::CFG_SECOND_OFFSET: r_second_offset <= i_cfg_data;
                fwr_pkg::CFG_SECOND_WORDS:  r_second_words  <= i_cfg_data[3:0];
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fwr_pkg::S_IDLE;
            r_in_frame    <= 1'b0;
            r_count       <= '0;
            r_first_zero  <= 1'b1;
            r_second_zero <= 1'b1;
            r_first_seen  <= 1'b0;
            r_second_seen <= 1'b0;
            r_first_code  <= fwr_pkg::STAT_IDLE;
            r_second_code <= fwr_pkg::STAT_IDLE;
            r_ov          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_in_frame    <= n_in_frame;
            r_count       <= n_count;
            r_first_zero  <= n_first_zero;
            r_second_zero <= n_second_zero;
            r_first_seen  <= n_first_seen;
            r_second_seen <= n_second_seen;
            r_first_code  <= n_first_code;
            r_second_code <= n_second_code;
            r_ov          <= n_ov;
        end
    end

    // Payload and readout position registers
    always_ff @(posedge i_clk) begin
        r_emit    <= n_emit;
        r_grp     <= n_grp;
        r_idx     <= n_idx;
        r_lo      <= n_lo;
        r_hi_byte <= n_hi_byte;
        r_out     <= n_out;
        if (ram_re) begin
            r_rd_ok <= rd_ok;
        end
    end

    // Drive the result channel
    assign o_res.valid         = r_ov;
    assign o_res.kind          = r_out.kind;
    assign o_res.word_index    = r_out.word_index;
    assign o_res.word_value    = r_out.word_value;
    assign o_res.first_status  = r_out.first_status;
    assign o_res.second_status = r_out.second_status;
    assign o_res.last          = r_out.last;

    // Word beats always carry a judged status
    a_word_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.kind != fwr_pkg::KIND_STATUS) |->
        (r_out.first_status != fwr_pkg::STAT_DROPPED &&
         r_out.first_status != fwr_pkg::STAT_IDLE &&
         r_out.second_status != fwr_pkg::STAT_DROPPED &&
         r_out.second_status != fwr_pkg::STAT_IDLE))
        else $error("word beat with unjudged status");

    // Readout only runs on a closed frame with a nonzero frozen length
    a_readout_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fwr_pkg::S_IDLE) |-> (!r_in_frame && r_count != '0))
        else $error("readout without a closed frame");

    // A stray byte reports both groups dropped on the next beat
    a_stray_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_accept && stray) |=>
        (o_res.valid && o_res.first_status == fwr_pkg::STAT_DROPPED &&
         o_res.second_status == fwr_pkg::STAT_DROPPED && o_res.last))
        else $error("stray byte not reported as dropped");

    // The buffer is written only while idle, never during a readout
    a_write_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == fwr_pkg::S_IDLE && !ram_re))
        else $error("buffer write overlaps readout");

endmodule

`default_nettype wire
